// ===== rtl/core/tbvt_pkg.sv =====
// Package for the branch visibility table: sizes, codes, state and result types.
// No dependencies.
package tbvt_pkg;
    localparam int MAX_BRANCHES = 16;
    localparam int IDX_W  = $clog2(MAX_BRANCHES);
    localparam int CNT_W  = $clog2(MAX_BRANCHES + 1);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int POS_W  = 21;
    localparam int ID_W   = 32;
    localparam int HND_W  = 2 * ID_W;
    localparam int ST_W   = 3;
    localparam int IN_W   = 224;
    localparam int OUT_W  = 16;

    typedef logic signed [POS_W-1:0] pos_t;
    localparam pos_t POS_NONE = '1;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 3'd0,
        ST_HANDLE = 3'd1,
        ST_DUP    = 3'd2,
        ST_PARENT = 3'd3,
        ST_FORK   = 3'd4,
        ST_FULL   = 3'd5,
        ST_IDLE   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PTIP,
        S_PCHK,
        S_COPY,
        S_QRY,
        S_RESP
    } state_t;

    typedef struct packed {
        logic       valid;
        status_t    status;
        logic       visible;
        logic [4:0] index;
    } resp_t;
endpackage

// ===== rtl/core/tbvt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tbvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== rtl/core/tbvt_core.sv =====
// Sequencer for build, add and query commands over the cutoff and handle RAMs.
// Depends on tbvt_pkg and tbvt_ram.
module tbvt_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tbvt_pkg::cmd_t               cmd,
    input  logic [tbvt_pkg::ID_W-1:0]    bid,
    input  logic [tbvt_pkg::ID_W-1:0]    bgen,
    input  logic [tbvt_pkg::ID_W-1:0]    pid,
    input  logic [tbvt_pkg::ID_W-1:0]    pgen,
    input  tbvt_pkg::pos_t               tip,
    input  tbvt_pkg::pos_t               fork_pos,
    input  logic                         last,
    input  logic [4:0]                   qbr,
    input  tbvt_pkg::pos_t               qpos,
    input  logic [4:0]                   kbr,
    input  tbvt_pkg::pos_t               kpos,
    input  logic [tbvt_pkg::ID_W-1:0]    invalid_id,
    input  logic                         out_free,
    output tbvt_pkg::resp_t              resp
);
    tbvt_pkg::state_t state_reg, state_next;

    logic [tbvt_pkg::CNT_W-1:0] added_reg, added_next;
    logic [tbvt_pkg::CNT_W-1:0] committed_reg, committed_next;
    logic failed_reg, failed_next, building_reg, building_next;

    logic [tbvt_pkg::ID_W-1:0] bid_reg, bgen_reg, pid_reg, pgen_reg;
    logic [tbvt_pkg::ID_W-1:0] bid_next, bgen_next, pid_next, pgen_next;
    tbvt_pkg::pos_t tip_reg, fork_reg, qpos_reg, kpos_reg;
    tbvt_pkg::pos_t tip_next, fork_next, qpos_next, kpos_next;
    logic last_reg, last_next;
    logic [4:0] qbr_reg, kbr_reg, qbr_next, kbr_next;

    logic [tbvt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic chk_vld_reg, chk_vld_next;
    logic [tbvt_pkg::IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic dup_reg, dup_next, pfound_reg, pfound_next, root_reg, root_next;
    logic [tbvt_pkg::IDX_W-1:0] pidx_reg, pidx_next;
    tbvt_pkg::resp_t res_reg, res_next;

    logic tw_en, hw_en;
    logic [tbvt_pkg::ADDR_W-1:0] tw_addr, tr_addr;
    tbvt_pkg::pos_t tw_data, tr_data;
    logic [tbvt_pkg::HND_W-1:0] hr_data;

    logic [tbvt_pkg::IDX_W-1:0] row;
    logic accept, scan_done, fail;
    tbvt_pkg::status_t fail_code;
    logic bad_handle, is_root, fork_bad, qvis;

    tbvt_ram #(.WIDTH(tbvt_pkg::POS_W), .DEPTH(tbvt_pkg::MAX_BRANCHES * tbvt_pkg::MAX_BRANCHES))
    u_table (
        .aclk(aclk), .wr_en(tw_en), .wr_addr(tw_addr), .wr_data(tw_data),
        .rd_addr(tr_addr), .rd_data(tr_data)
    );

    tbvt_ram #(.WIDTH(tbvt_pkg::HND_W), .DEPTH(tbvt_pkg::MAX_BRANCHES)) u_handles (
        .aclk(aclk), .wr_en(hw_en), .wr_addr(row), .wr_data({bgen_reg, bid_reg}),
        .rd_addr(cnt_reg[tbvt_pkg::IDX_W-1:0]), .rd_data(hr_data)
    );

    assign in_ready  = (state_reg == tbvt_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign row       = added_reg[tbvt_pkg::IDX_W-1:0];
    assign scan_done = (cnt_reg == added_reg) && !chk_vld_reg;
    assign bad_handle = (bid == invalid_id) || (tip < tbvt_pkg::POS_NONE)
                        || (fork_pos < tbvt_pkg::POS_NONE);
    assign is_root   = (pid_reg == invalid_id);
    assign fork_bad  = (fork_reg < 0) || (fork_reg > tr_data) || (fork_reg > tip_reg);
    assign qvis = !failed_reg && ({1'b0, qbr_reg} < {1'b0, committed_reg})
                  && ({1'b0, kbr_reg} < {1'b0, committed_reg})
                  && (qpos_reg >= 0) && (kpos_reg >= 0) && (kpos_reg <= qpos_reg)
                  && (kpos_reg <= tr_data);

    // result is offered only once it is complete
    always_comb begin
        resp = res_reg;
        resp.valid = (state_reg == tbvt_pkg::S_RESP);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tbvt_pkg::S_IDLE: begin
                if (accept) begin
                    if (cmd == tbvt_pkg::CMD_QUERY) begin
                        state_next = tbvt_pkg::S_QRY;
                    end else if (cmd == tbvt_pkg::CMD_ADD && building_reg
                                 && added_reg < tbvt_pkg::CNT_W'(tbvt_pkg::MAX_BRANCHES)
                                 && !bad_handle) begin
                        state_next = tbvt_pkg::S_SCAN;
                    end else begin
                        state_next = tbvt_pkg::S_RESP;
                    end
                end
            end
            tbvt_pkg::S_SCAN: begin
                if (scan_done) begin
                    if (dup_reg || (is_root && fork_reg != tbvt_pkg::POS_NONE)
                        || (!is_root && !pfound_reg)) begin
                        state_next = tbvt_pkg::S_RESP;
                    end else if (is_root) begin
                        state_next = tbvt_pkg::S_COPY;
                    end else begin
                        state_next = tbvt_pkg::S_PTIP;
                    end
                end
            end
            tbvt_pkg::S_PTIP: state_next = tbvt_pkg::S_PCHK;
            tbvt_pkg::S_PCHK: state_next = fork_bad ? tbvt_pkg::S_RESP : tbvt_pkg::S_COPY;
            tbvt_pkg::S_COPY: begin
                if (cnt_reg == tbvt_pkg::CNT_W'(tbvt_pkg::MAX_BRANCHES) && !chk_vld_reg) begin
                    state_next = tbvt_pkg::S_RESP;
                end
            end
            tbvt_pkg::S_QRY:  state_next = tbvt_pkg::S_RESP;
            tbvt_pkg::S_RESP: state_next = out_free ? tbvt_pkg::S_IDLE : tbvt_pkg::S_RESP;
            default:          state_next = tbvt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        added_next = added_reg;  committed_next = committed_reg;
        failed_next = failed_reg; building_next = building_reg;
        bid_next = bid_reg; bgen_next = bgen_reg; pid_next = pid_reg; pgen_next = pgen_reg;
        tip_next = tip_reg; fork_next = fork_reg; last_next = last_reg;
        qbr_next = qbr_reg; kbr_next = kbr_reg; qpos_next = qpos_reg; kpos_next = kpos_reg;
        cnt_next = cnt_reg; chk_vld_next = 1'b0; chk_idx_next = chk_idx_reg;
        dup_next = dup_reg; pfound_next = pfound_reg; pidx_next = pidx_reg;
        root_next = root_reg;
        res_next = res_reg;
        tw_en = 1'b0; tw_addr = {row, chk_idx_reg}; tw_data = tbvt_pkg::POS_NONE;
        tr_addr = {pidx_reg, cnt_reg[tbvt_pkg::IDX_W-1:0]};
        hw_en = 1'b0;
        fail = 1'b0; fail_code = tbvt_pkg::ST_OK;

        case (state_reg)
            tbvt_pkg::S_IDLE: begin
                tr_addr = {qbr[tbvt_pkg::IDX_W-1:0], kbr[tbvt_pkg::IDX_W-1:0]};
                if (accept) begin
                    bid_next = bid; bgen_next = bgen; pid_next = pid; pgen_next = pgen;
                    tip_next = tip; fork_next = fork_pos; last_next = last;
                    qbr_next = qbr; kbr_next = kbr; qpos_next = qpos; kpos_next = kpos;
                    cnt_next = '0; dup_next = 1'b0; pfound_next = 1'b0;
                    res_next = '{valid: 1'b1, status: tbvt_pkg::ST_OK,
                                 visible: 1'b0, index: '0};
                    case (cmd)
                        tbvt_pkg::CMD_BEGIN: begin
                            added_next = '0; committed_next = '0;
                            failed_next = 1'b0; building_next = 1'b1;
                        end
                        tbvt_pkg::CMD_ADD: begin
                            if (!building_reg) begin
                                res_next.status = tbvt_pkg::ST_IDLE;
                            end else if (added_reg >= tbvt_pkg::CNT_W'(tbvt_pkg::MAX_BRANCHES)) begin
                                fail = 1'b1; fail_code = tbvt_pkg::ST_FULL;
                            end else if (bad_handle) begin
                                fail = 1'b1; fail_code = tbvt_pkg::ST_HANDLE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            tbvt_pkg::S_SCAN: begin
                root_next = is_root;
                if (cnt_reg < added_reg) begin
                    cnt_next = cnt_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = cnt_reg[tbvt_pkg::IDX_W-1:0];
                end
                if (chk_vld_reg) begin
                    if (hr_data == {bgen_reg, bid_reg}) dup_next = 1'b1;
                    if (hr_data == {pgen_reg, pid_reg} && !pfound_reg) begin
                        pfound_next = 1'b1;
                        pidx_next = chk_idx_reg;
                    end
                end
                if (scan_done) begin
                    cnt_next = '0;
                    if (dup_reg) begin
                        fail = 1'b1; fail_code = tbvt_pkg::ST_DUP;
                    end else if (is_root && fork_reg != tbvt_pkg::POS_NONE) begin
                        fail = 1'b1; fail_code = tbvt_pkg::ST_FORK;
                    end else if (!is_root && !pfound_reg) begin
                        fail = 1'b1; fail_code = tbvt_pkg::ST_PARENT;
                    end
                end
            end
            tbvt_pkg::S_PTIP: tr_addr = {pidx_reg, pidx_reg};
            tbvt_pkg::S_PCHK: begin
                if (fork_bad) begin
                    fail = 1'b1; fail_code = tbvt_pkg::ST_FORK;
                end
            end
            tbvt_pkg::S_COPY: begin
                if (cnt_reg < tbvt_pkg::CNT_W'(tbvt_pkg::MAX_BRANCHES)) begin
                    cnt_next = cnt_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = cnt_reg[tbvt_pkg::IDX_W-1:0];
                end
                if (chk_vld_reg) begin
                    tw_en = 1'b1;
                    if (chk_idx_reg == row) begin
                        tw_data = tip_reg;
                    end else if ({1'b0, chk_idx_reg} < added_reg && !root_reg && tr_data >= 0) begin
                        tw_data = (tr_data < fork_reg) ? tr_data : fork_reg;
                    end
                end
                if (cnt_reg == tbvt_pkg::CNT_W'(tbvt_pkg::MAX_BRANCHES) && !chk_vld_reg) begin
                    hw_en = 1'b1;
                    added_next = added_reg + 1'b1;
                    res_next.index = 5'(added_reg);
                    if (last_reg) begin
                        committed_next = added_reg + 1'b1;
                        building_next = 1'b0;
                    end
                end
            end
            tbvt_pkg::S_QRY: res_next.visible = qvis;
            default: ;
        endcase

        if (fail) begin
            failed_next = 1'b1; building_next = 1'b0;
            res_next.status = fail_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tbvt_pkg::S_IDLE;
            added_reg <= '0; committed_reg <= '0;
            failed_reg <= 1'b0; building_reg <= 1'b0;
            chk_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            added_reg <= added_next; committed_reg <= committed_next;
            failed_reg <= failed_next; building_reg <= building_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        bid_reg <= bid_next; bgen_reg <= bgen_next; pid_reg <= pid_next; pgen_reg <= pgen_next;
        tip_reg <= tip_next; fork_reg <= fork_next; last_reg <= last_next;
        qbr_reg <= qbr_next; kbr_reg <= kbr_next; qpos_reg <= qpos_next; kpos_reg <= kpos_next;
        cnt_reg <= cnt_next; chk_idx_reg <= chk_idx_next;
        dup_reg <= dup_next; pfound_reg <= pfound_next; pidx_reg <= pidx_next;
        root_reg <= root_next; res_reg <= res_next;
    end
endmodule

// ===== rtl/core/tree_branch_kv_visibility_table.sv =====
// Top level: stream ports, config register, result register around the sequencer.
// Depends on tbvt_pkg and tbvt_core.
//
// Usage: s_ carries commands (tuser: begin, add, query), m_ carries one result
// item per command. cfg_ writes the invalid branch id; the user writes it only
// while the block is idle, which the block itself does not enforce. Begin resets
// the build; adds follow, the one with tlast commits the table; queries then read
// one cutoff from the table. An add scans the handles, then for a non-root branch
// reads the parent's tip and checks the fork point, then copies the parent row
// into the table RAM; an error ends it early.
// The result item shows on m_ in the same cycle that the next item can be taken.
// Only one item is worked on at a time; s_tready is high while the sequencer is idle.
// Results sit in an output register, so a new item is taken while m_ is stalled;
// the sequencer then holds its finished result until the register frees.
// Reset (aresetn low, synchronous) clears counts and flags; no build is active
// and the invalid id returns to all ones. Table RAM needs no clearing pass:
// every added row is written in full.
module tree_branch_kv_visibility_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [31:0] branch_id, [63:32] branch_generation, [95:64] parent_id,
    // [127:96] parent_generation, [148:128] own tip, [169:149] fork point,
    // [174:170] query row, [195:175] query pos, [200:196] key row,
    // [221:201] key pos, rest zero
    input  logic [tbvt_pkg::IN_W-1:0]    s_tdata,
    input  logic [1:0]                   s_tuser,    // [1:0] command
    input  logic                         s_tlast,    // last_branch
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [2:0] status, [3] visible, [8:4] assigned_index, rest zero
    output logic [tbvt_pkg::OUT_W-1:0]   m_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tbvt_pkg::ID_W-1:0]    cfg_data
);
    logic [tbvt_pkg::ID_W-1:0] inv_id_reg, inv_id_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [8:0] m_data_reg, m_data_next;
    logic out_free;
    tbvt_pkg::resp_t resp;

    tbvt_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .cmd(tbvt_pkg::cmd_t'(s_tuser)),
        .bid(s_tdata[31:0]), .bgen(s_tdata[63:32]),
        .pid(s_tdata[95:64]), .pgen(s_tdata[127:96]),
        .tip(s_tdata[148:128]), .fork_pos(s_tdata[169:149]),
        .last(s_tlast),
        .qbr(s_tdata[174:170]), .qpos(s_tdata[195:175]),
        .kbr(s_tdata[200:196]), .kpos(s_tdata[221:201]),
        .invalid_id(inv_id_reg), .out_free(out_free), .resp(resp)
    );

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, m_data_reg};

    always_comb begin
        inv_id_next   = cfg_valid ? cfg_data : inv_id_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        if (resp.valid && out_free) begin
            m_tvalid_next = 1'b1;
            m_data_next   = {resp.index, resp.visible, resp.status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_id_reg   <= '1;
            m_tvalid_reg <= 1'b0;
        end else begin
            inv_id_reg   <= inv_id_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end
endmodule
